// ===== hw/rtl/wwlc_pkg.sv =====
// Shared types, codes and geometry constants of the write wear line counter.
package wwlc_pkg;

	// Default sizes of the wear store.
	localparam int LINE_COUNT_DEF  = 4096;
	localparam int COUNT_WIDTH_DEF = 16;

	// Line and block geometry, both powers of two.
	localparam int LINE_BYTES      = 8;
	localparam int BLOCK_BYTES     = 64;
	localparam int LB_SH           = $clog2(LINE_BYTES);
	localparam int LINES_PER_BLOCK = (BLOCK_BYTES / LINE_BYTES > 0) ?
		BLOCK_BYTES / LINE_BYTES : 1;
	localparam int PB_SH           = $clog2(LINES_PER_BLOCK);

	// Field widths.
	localparam int ADDR_W           = 64;
	localparam int SIZE_W           = 32;
	localparam int BLOCK_W          = 9;
	localparam int RLINES_W         = 13;
	localparam int WEAR_W           = 16;
	localparam int STATUS_W         = 2;
	localparam int IN_DATA_W        = 112;
	localparam int OUT_DATA_W       = 24;
	localparam int CFG_INDEX_W      = 1;
	localparam int CFG_DATA_W       = 64;
	localparam int REGION_LINES_RST = 4096;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_QUERY = 1'b1
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 2'd0,
		STS_PARTIAL = 2'd1,
		STS_OUTSIDE = 2'd2
	} status_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_REGION_START = 1'b0,
		CFG_REGION_LINES = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_REL,
		ST_END,
		ST_SPAN,
		ST_RUN,
		ST_DRAIN,
		ST_RESP
	} state_t;

	// Commands from the sequencer to the wear store.
	typedef struct packed {
		logic rd_en;
		logic rd_write;
		logic wr_zero;
		logic acc_clr;
	} store_cmd_t;

	// Finished result handed to the output register.
	typedef struct packed {
		logic    valid;
		logic    query;
		status_t status;
	} result_t;

endpackage

// ===== hw/rtl/write_wear_line_counter.sv =====
// Top level of the write wear line counter: ports, configuration and result register.
//
//  channel  | direction | handshake               | payload
//  s_axis   | in        | s_axis_tvalid/tready    | tuser kind, tdata address, size, block_index
//  m_axis   | out       | m_axis_tvalid/tready    | tdata block_wear, status
//  cfg      | in        | cfg_valid/cfg_ready     | cfg_index, cfg_data
//
// A write passes ST_REL, ST_END and ST_SPAN, then ST_RUN over its tracked lines, ST_DRAIN
// and ST_RESP; one touching none goes from ST_SPAN to ST_RESP. A query passes ST_REL, then
// ST_RUN over its tracked lines, ST_DRAIN and ST_RESP. A zero-size write or an outside block
// goes from ST_REL to ST_RESP. The store has a single read and write port.
// After reset a clearing sweep zeroes every line, during which no item is taken.
// A result waits in the output register while the next item is already accepted.
// Configuration is always ready.
module write_wear_line_counter #(
	parameter int LINE_COUNT  = wwlc_pkg::LINE_COUNT_DEF,
	parameter int COUNT_WIDTH = wwlc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: address [63:0], size [95:64], block_index [104:96], zero pad above
	input  logic [wwlc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// tuser: kind [0]
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: block_wear [15:0], status [17:16], zero pad above
	output logic [wwlc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [wwlc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [wwlc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wwlc_pkg::*;

	localparam int AW = $clog2(LINE_COUNT);

	logic [ADDR_W-1:0]      region_start_q;
	logic [RLINES_W-1:0]    region_lines_q;
	logic                   m_valid_q;
	logic [OUT_DATA_W-1:0]  m_data_q;
	logic                   out_free;
	store_cmd_t             cmd;
	logic [AW-1:0]          line_addr;
	result_t                res;
	logic [COUNT_WIDTH-1:0] best;
	logic [WEAR_W-1:0]      wear;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_start_q <= '0;
			region_lines_q <= RLINES_W'(REGION_LINES_RST);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_REGION_START: region_start_q <= cfg_data;
				CFG_REGION_LINES: region_lines_q <= cfg_data[RLINES_W-1:0];
				default:          region_start_q <= region_start_q;
			endcase
		end
	end

	wwlc_ctrl #(
		.LINE_COUNT(LINE_COUNT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.kind         (s_axis_tuser),
		.address      (s_axis_tdata[ADDR_W-1:0]),
		.size         (s_axis_tdata[ADDR_W+SIZE_W-1:ADDR_W]),
		.block_index  (s_axis_tdata[ADDR_W+SIZE_W+BLOCK_W-1:ADDR_W+SIZE_W]),
		.region_start (region_start_q),
		.region_lines (region_lines_q),
		.out_free     (out_free),
		.cmd          (cmd),
		.addr         (line_addr),
		.res          (res)
	);

	wwlc_store #(
		.LINE_COUNT  (LINE_COUNT),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.addr   (line_addr),
		.best   (best)
	);

	// Block maximum clipped to the reported width; writes report zero.
	always_comb begin
		if (!res.query) begin
			wear = '0;
		end else if (best > COUNT_WIDTH'({WEAR_W{1'b1}})) begin
			wear = '1;
		end else begin
			wear = WEAR_W'(best);
		end
	end

	// Output register.
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res.valid) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			m_data_q <= OUT_DATA_W'({res.status, wear});
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ===== hw/rtl/wwlc_store.sv =====
// Wear store: line counter memory, read-modify-write stage and block maximum.
module wwlc_store #(
	parameter int LINE_COUNT  = wwlc_pkg::LINE_COUNT_DEF,
	parameter int COUNT_WIDTH = wwlc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  wwlc_pkg::store_cmd_t            cmd,
	input  logic [$clog2(LINE_COUNT)-1:0]   addr,
	output logic [COUNT_WIDTH-1:0]          best
);
	import wwlc_pkg::*;

	localparam int AW = $clog2(LINE_COUNT);

	logic [COUNT_WIDTH-1:0] mem [LINE_COUNT];
	logic [COUNT_WIDTH-1:0] rd_data_s1;
	logic [AW-1:0]          addr_s1;
	logic                   valid_s1;
	logic                   write_s1;
	logic [COUNT_WIDTH-1:0] bumped;
	logic [COUNT_WIDTH-1:0] best_q;

	// Saturating increment of the line just read.
	assign bumped = (rd_data_s1 == '1) ? rd_data_s1 : rd_data_s1 + COUNT_WIDTH'(1);

	// Memory: one write port (clear or write-back), one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_zero) begin
			mem[addr] <= '0;
		end else if (valid_s1 && write_s1) begin
			mem[addr_s1] <= bumped;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[addr];
		end
		addr_s1  <= addr;
		write_s1 <= cmd.rd_write;
	end

	// Read valid flag of the write-back stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.rd_en;
		end
	end

	// Running maximum over the lines of a queried block.
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			best_q <= '0;
		end else if (valid_s1 && !write_s1 && rd_data_s1 > best_q) begin
			best_q <= rd_data_s1;
		end
	end

	assign best = best_q;

endmodule

// ===== hw/rtl/wwlc_ctrl.sv =====
// Sequencer: region arithmetic, line range of each item and store commands.
module wwlc_ctrl #(
	parameter int LINE_COUNT = wwlc_pkg::LINE_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                kind,
	input  logic [wwlc_pkg::ADDR_W-1:0]         address,
	input  logic [wwlc_pkg::SIZE_W-1:0]         size,
	input  logic [wwlc_pkg::BLOCK_W-1:0]        block_index,
	input  logic [wwlc_pkg::ADDR_W-1:0]         region_start,
	input  logic [wwlc_pkg::RLINES_W-1:0]       region_lines,
	input  logic                                out_free,
	output wwlc_pkg::store_cmd_t                cmd,
	output logic [$clog2(LINE_COUNT)-1:0]       addr,
	output wwlc_pkg::result_t                   res
);
	import wwlc_pkg::*;

	localparam int AW   = $clog2(LINE_COUNT);
	localparam int NW   = $clog2(LINE_COUNT + 1);
	localparam int RBW  = NW + LB_SH;
	localparam int MW   = (NW > RLINES_W) ? NW : RLINES_W;
	localparam int QW   = BLOCK_W + PB_SH;
	localparam int CMPW = ((QW > NW) ? QW : NW) + 1;

	state_t              state_q, state_d;
	logic [AW-1:0]       cur_q, cur_d;
	logic [AW-1:0]       last_q;
	kind_t               kind_q;
	logic [ADDR_W-1:0]   address_q;
	logic [SIZE_W-1:0]   size_q;
	logic [BLOCK_W-1:0]  block_q;
	logic [ADDR_W-1:0]   rel_q;
	logic [ADDR_W-1:0]   end_q;
	logic                carry_q;
	logic                inreg_q;
	status_t             status_q;

	logic [MW-1:0]       rl_ext;
	logic [NW-1:0]       lines;
	logic [RBW-1:0]      rbytes;
	logic [CMPW-1:0]     q_first;
	logic [CMPW-1:0]     q_next;
	logic [CMPW-1:0]     lines_ext;
	logic                q_outside;
	logic [AW-1:0]       q_last;
	logic [ADDR_W:0]     sum;
	logic                rel_in;
	logic                end_over;
	logic [RBW-1:0]      end_m1;
	logic [AW-1:0]       w_last;
	logic                wrap_hit;

	// Lines in use and the byte length of the tracked region.
	always_comb begin
		rl_ext = MW'(region_lines);
		lines  = (rl_ext < MW'(LINE_COUNT)) ? NW'(rl_ext) : NW'(LINE_COUNT);
		rbytes = {lines, {LB_SH{1'b0}}};
	end

	// Query range: the block's lines clipped to the region.
	always_comb begin
		q_first   = CMPW'({block_q, {PB_SH{1'b0}}});
		q_next    = q_first + CMPW'(LINES_PER_BLOCK);
		lines_ext = CMPW'(lines);
		q_outside = q_first >= lines_ext;
		q_last    = (q_next > lines_ext) ? AW'(lines_ext - CMPW'(1)) : AW'(q_next - CMPW'(1));
	end

	// Write range: relative end of the write and its last tracked line.
	always_comb begin
		sum      = {1'b0, rel_q} + {{(ADDR_W - SIZE_W + 1){1'b0}}, size_q};
		rel_in   = (rel_q[ADDR_W-1:RBW] == '0) && (rel_q[RBW-1:0] < rbytes);
		end_over = (end_q[ADDR_W-1:RBW] != '0) || (end_q[RBW-1:0] > rbytes);
		end_m1   = end_q[RBW-1:0] - RBW'(1);
		w_last   = end_over ? AW'(lines - NW'(1)) : AW'(end_m1 >> LB_SH);
		wrap_hit = carry_q && (end_q != '0) && (lines != '0);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (cur_q == AW'(LINE_COUNT - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_REL;
			end
			ST_REL: begin
				if (kind_q == KIND_QUERY) begin
					state_d = q_outside ? ST_RESP : ST_RUN;
				end else begin
					state_d = (size_q == '0) ? ST_RESP : ST_END;
				end
			end
			ST_END: begin
				state_d = ST_SPAN;
			end
			ST_SPAN: begin
				state_d = (inreg_q || wrap_hit) ? ST_RUN : ST_RESP;
			end
			ST_RUN: begin
				if (cur_q == last_q) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		res          = '0;
		addr         = cur_q;
		cmd.rd_write = (kind_q == KIND_WRITE);
		res.query    = (kind_q == KIND_QUERY);
		res.status   = status_q;
		case (state_q)
			ST_CLEAR: cmd.wr_zero = 1'b1;
			ST_IDLE:  in_ready    = 1'b1;
			ST_REL:   cmd.acc_clr = 1'b1;
			ST_RUN:   cmd.rd_en   = 1'b1;
			ST_RESP:  res.valid   = out_free;
			default:  cmd.rd_en   = 1'b0;
		endcase
	end

	// Line pointer: clearing sweep, then the range of each item.
	always_comb begin
		cur_d = cur_q;
		case (state_q)
			ST_CLEAR: cur_d = cur_q + AW'(1);
			ST_REL:   cur_d = AW'(q_first);
			ST_SPAN:  cur_d = inreg_q ? AW'(rel_q[RBW-1:LB_SH]) : '0;
			ST_RUN:   cur_d = cur_q + AW'(1);
			default:  cur_d = cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cur_q   <= '0;
		end else begin
			state_q <= state_d;
			cur_q   <= cur_d;
		end
	end

	// Item registers and region arithmetic, one wide step per cycle.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q    <= kind_t'(kind);
				address_q <= address;
				size_q    <= size;
				block_q   <= block_index;
			end
			ST_REL: begin
				rel_q  <= address_q - region_start;
				last_q <= q_last;
				if (kind_q == KIND_QUERY) begin
					status_q <= q_outside ? STS_OUTSIDE : STS_OK;
				end else begin
					status_q <= STS_OK;
				end
			end
			ST_END: begin
				end_q   <= sum[ADDR_W-1:0];
				carry_q <= sum[ADDR_W];
				inreg_q <= rel_in;
			end
			ST_SPAN: begin
				last_q   <= w_last;
				status_q <= (inreg_q && !end_over) ? STS_OK : STS_PARTIAL;
			end
			default: begin
				last_q <= last_q;
			end
		endcase
	end

endmodule

// ===== hw/rtl/wwlc_checker.sv =====
// Port-level checker of the write wear line counter and its bind.
module wwlc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [111:0] s_axis_tdata,
	input logic         s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [23:0]  m_axis_tdata,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic [0:0]   cfg_index,
	input logic [63:0]  cfg_data
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// One item at a time: no item is taken in the cycle after an accepted item.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("item accepted while another is at work");

	// A block outside the region reports no wear.
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[17:16] == 2'd2 |-> m_axis_tdata[15:0] == 16'd0)
		else $error("outside block reported wear");

	// Status code three is never produced and the padding stays zero.
	a_status_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[17:16] != 2'd3 && m_axis_tdata[23:18] == 6'd0)
		else $error("bad status or padding in result");

endmodule

bind write_wear_line_counter wwlc_checker u_wwlc_checker (.*);

// ===== tb/tb_write_wear_line_counter.sv =====
// Self-checking testbench of the write wear line counter: directed, line hammering and random traffic.
module tb_write_wear_line_counter;
	timeunit 1ns;
	timeprecision 1ps;

	import wwlc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int IN_PAD_W       = IN_DATA_W - ADDR_W - SIZE_W - BLOCK_W;

	// One expected result: the block maximum and the status code.
	typedef struct packed {
		logic [WEAR_W-1:0] wear;
		status_t           status;
	} wear_result_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;
	logic                   s_axis_tuser  = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   cfg_valid     = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index     = '0;
	logic [CFG_DATA_W-1:0]  cfg_data      = '0;

	// Shadow copy of the wear store and of the region registers.
	logic [COUNT_WIDTH_DEF-1:0] line_wear_shadow [LINE_COUNT_DEF];
	logic [ADDR_W-1:0]          region_base;
	logic [RLINES_W-1:0]        region_span;
	wear_result_t               pending_wear_results [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_request   = 0;
	int hold_left      = 0;
	int error_count    = 0;
	int idle_cycles    = 0;

	write_wear_line_counter i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Number of lines actually tracked under the current region size.
	function automatic int tracked_lines();
		return (int'(region_span) < LINE_COUNT_DEF) ? int'(region_span) : LINE_COUNT_DEF;
	endfunction

	// Saturating increment of a run of line counters.
	task automatic bump_line_wear(input int first, input int last);
		for (int n = first; n <= last && n < LINE_COUNT_DEF; n++) begin
			if (line_wear_shadow[n] != '1)
				line_wear_shadow[n] = line_wear_shadow[n] + 1'b1;
		end
	endtask

	// Applies a write to the shadow store and works out its status.
	task automatic predict_write_status(input logic [ADDR_W-1:0] addr,
		input logic [SIZE_W-1:0] size, output status_t status);
		logic [63:0] span_bytes;
		logic [63:0] rel;
		logic [63:0] top;
		logic [64:0] reach;
		status     = STS_OK;
		span_bytes = 64'(tracked_lines()) * LINE_BYTES;
		rel        = addr - region_base;
		if (size != '0) begin
			if (rel < span_bytes) begin
				top = rel + 64'(size) - 64'd1;
				if (top >= span_bytes) begin
					top    = span_bytes - 64'd1;
					status = STS_PARTIAL;
				end
				bump_line_wear(int'(rel >> LB_SH), int'(top >> LB_SH));
			end else begin
				// Start lies outside; only a write that wraps past the top reaches line zero.
				status = STS_PARTIAL;
				reach  = {1'b0, rel} + 65'(size);
				if (reach > {1'b1, 64'd0} && span_bytes != 64'd0) begin
					top = reach[63:0] - 64'd1;
					if (top >= span_bytes)
						top = span_bytes - 64'd1;
					bump_line_wear(0, int'(top >> LB_SH));
				end
			end
		end
	endtask

	// Largest tracked counter in one block.
	task automatic predict_block_wear(input logic [BLOCK_W-1:0] blk,
		output logic [WEAR_W-1:0] wear, output status_t status);
		int          first;
		int          lines;
		int unsigned best;
		lines  = tracked_lines();
		first  = int'(blk) * LINES_PER_BLOCK;
		best   = 0;
		wear   = '0;
		status = STS_OUTSIDE;
		if (first < lines) begin
			for (int n = first; n < first + LINES_PER_BLOCK && n < lines; n++) begin
				if (int'(line_wear_shadow[n]) > best)
					best = 32'(line_wear_shadow[n]);
			end
			wear   = (best > 32'hFFFF) ? 16'hFFFF : 16'(best);
			status = STS_OK;
		end
	endtask

	// Offers one item, waits for it to be taken and records its expected result.
	task automatic send_item(input kind_t kind, input logic [ADDR_W-1:0] addr,
		input logic [SIZE_W-1:0] size, input logic [BLOCK_W-1:0] blk);
		wear_result_t want;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {{IN_PAD_W{1'b0}}, blk, size, addr};
		do @(posedge clk); while (!s_axis_tready);
		if (kind == KIND_WRITE) begin
			want.wear = '0;
			predict_write_status(addr, size, want.status);
		end else begin
			predict_block_wear(blk, want.wear, want.status);
		end
		pending_wear_results = {pending_wear_results, want};
	endtask

	// Stops offering items and waits until every result has come back.
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (pending_wear_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; the shadow copy follows at acceptance.
	task automatic write_config(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_REGION_START)
			region_base = value;
		else
			region_span = value[RLINES_W-1:0];
		@(posedge clk);
	endtask

	// Mostly writes and queries around the region, with some noise addresses.
	task automatic send_random_item();
		int unsigned        span_bytes;
		int unsigned        span_blocks;
		int unsigned        pick;
		logic [ADDR_W-1:0]  addr;
		logic [SIZE_W-1:0]  size;
		logic [BLOCK_W-1:0] blk;
		span_bytes  = tracked_lines() * LINE_BYTES;
		span_blocks = (tracked_lines() + LINES_PER_BLOCK - 1) / LINES_PER_BLOCK;
		addr        = {$urandom, $urandom};
		size        = $urandom;
		blk         = BLOCK_W'($urandom);
		pick        = $urandom_range(99);
		if (pick < 35) begin
			// Most queries name a tracked block or the first one past the end.
			if (pick >= 5)
				blk = BLOCK_W'($urandom_range(span_blocks, 0));
			send_item(KIND_QUERY, addr, size, blk);
		end else begin
			pick = $urandom_range(99);
			if (pick < 5)
				size = '0;
			else if (pick < 70)
				size = $urandom_range(32, 1);
			else if (pick < 90)
				size = $urandom_range(512, 33);
			else if (pick < 98)
				size = $urandom_range(8000, 513);
			pick = $urandom_range(99);
			if (pick < 75)
				addr = region_base + 64'($urandom_range(span_bytes + 64, 0));
			else if (pick < 88)
				addr = region_base - 64'($urandom_range(64, 1));
			send_item(KIND_WRITE, addr, size, blk);
		end
	endtask

	// Field extremes, region edges, wrap-around, empty and partial regions.
	task automatic test_directed_cases();
		send_item(KIND_QUERY, '0, '0, 9'd0);
		send_item(KIND_WRITE, 64'd0, 32'd0, '0);
		send_item(KIND_WRITE, 64'd3, 32'd0, '0);
		send_item(KIND_WRITE, 64'd0, 32'd1, '0);
		send_item(KIND_WRITE, 64'd7, 32'd2, '0);
		send_item(KIND_WRITE, 64'h7FF8, 32'd8, '1);
		send_item(KIND_WRITE, 64'h7FFC, 32'd16, '0);
		send_item(KIND_WRITE, 64'h8000, 32'd8, '0);
		send_item(KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFFC, 32'd12, '0);
		send_item(KIND_WRITE, '1, '1, '1);
		send_item(KIND_WRITE, 64'd16, '1, '0);
		send_item(KIND_QUERY, '1, '1, 9'd0);
		send_item(KIND_QUERY, '0, '0, 9'd1);
		send_item(KIND_QUERY, '0, '0, '1);
		wait_drain();

		// An empty region tracks nothing, even for a wrapping write.
		write_config(CFG_REGION_LINES, 64'd0);
		send_item(KIND_QUERY, '0, '0, 9'd0);
		send_item(KIND_WRITE, 64'd0, 32'd8, '0);
		send_item(KIND_WRITE, '1, 32'd16, '0);
		wait_drain();

		// A block only partly inside, and the first block past the end.
		write_config(CFG_REGION_LINES, 64'd13);
		send_item(KIND_QUERY, '0, '0, 9'd1);
		send_item(KIND_QUERY, '0, '0, 9'd2);
		wait_drain();

		// Region crossing the top of the address space; size above the store.
		write_config(CFG_REGION_START, 64'hFFFF_FFFF_FFFF_FFF0);
		write_config(CFG_REGION_LINES, 64'h1FFF);
		send_item(KIND_WRITE, 64'hFFFF_FFFF_FFFF_FFF8, 32'd24, '0);
		send_item(KIND_WRITE, 64'd0, 32'd8, '0);
		send_item(KIND_QUERY, '0, '0, 9'd0);
		send_item(KIND_QUERY, '0, '0, '1);
		wait_drain();
	endtask

	// Hammers one line with short writes, looking at its block along the way.
	task automatic test_line_hammer();
		write_config(CFG_REGION_START, 64'd0);
		write_config(CFG_REGION_LINES, 64'd4096);
		for (int i = 0; i < 24; i++) begin
			if (i % 8 == 0)
				send_item(KIND_QUERY, '0, '0, 9'd64);
			send_item(KIND_WRITE, 64'h1000 + 64'($urandom_range(7, 0)), 32'd1,
				BLOCK_W'($urandom));
		end
		send_item(KIND_QUERY, '0, '0, 9'd64);
		wait_drain();
	endtask

	// Receiver holds off long enough for the block to stop taking items.
	task automatic test_output_backpressure();
		write_config(CFG_REGION_START, {$urandom, $urandom});
		write_config(CFG_REGION_LINES, 64'd1);
		hold_request = 400;
		repeat (24) send_random_item();
		wait_drain();
	endtask

	// One phase of random traffic under a given region and idling mix.
	task automatic test_random_traffic(input int send_pct, input int recv_pct,
		input logic [ADDR_W-1:0] base, input logic [RLINES_W-1:0] span, input int count);
		write_config(CFG_REGION_START, base);
		write_config(CFG_REGION_LINES, CFG_DATA_W'(span));
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < count; i++) begin
			send_random_item();
			// Now and then the sender pauses until everything is back.
			if (i % 64 == 63)
				wait_drain();
		end
		wait_drain();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// Receiver: long hold-offs on request, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left     = hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compares each result with the oldest expectation.
	always @(posedge clk) begin : check_wear_results
		wear_result_t        want;
		logic [WEAR_W-1:0]   got_wear;
		logic [STATUS_W-1:0] got_status;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_wear   = m_axis_tdata[WEAR_W-1:0];
			got_status = m_axis_tdata[WEAR_W +: STATUS_W];
			if (pending_wear_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got wear %0d status %0d",
					$time, got_wear, got_status);
				error_count++;
			end else begin
				want = pending_wear_results.pop_front();
				if (got_wear !== want.wear) begin
					$display("%0t: block_wear mismatch, expected %0d, got %0d",
						$time, want.wear, got_wear);
					error_count++;
				end
				if (got_status !== want.status) begin
					$display("%0t: status mismatch, expected %0d, got %0d",
						$time, want.status, got_status);
					error_count++;
				end
			end
		end
	end

	// Ends the run when no item has moved on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// Reset, test sequence and final verdict.
	initial begin
		region_base = '0;
		region_span = RLINES_W'(REGION_LINES_RST);
		foreach (line_wear_shadow[n])
			line_wear_shadow[n] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_line_hammer();
		test_output_backpressure();
		test_random_traffic(0, 0, {$urandom, $urandom}, 13'd4096, 200);
		test_random_traffic(74, 0, '1, RLINES_W'($urandom_range(4096, 1)), 200);
		test_random_traffic(0, 74, {$urandom, $urandom}, RLINES_W'($urandom_range(64, 1)), 200);
		test_random_traffic(25, 25, 64'd0, 13'd4096, 200);

		wait_drain();
		if (error_count == 0 && pending_wear_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/wwlc_pkg.sv
hw/rtl/wwlc_store.sv
hw/rtl/wwlc_ctrl.sv
hw/rtl/write_wear_line_counter.sv
hw/rtl/wwlc_checker.sv
tb/tb_write_wear_line_counter.sv
